// ===== rtl/wfs_pkg.sv =====
// shared types and constants for the weighted fifo semaphore unit
`timescale 1ns / 1ps
`default_nettype none

package wfs_pkg;

  localparam int DEFAULT_HOLDERS = 16;
  localparam int ID_W            = 4;
  localparam int AMT_W           = 16;
  localparam int USE_W           = 20;
  localparam int OP_W            = 3;
  localparam int ST_W            = 3;
  localparam int IN_W            = 32;
  localparam int OUT_W           = 48;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [AMT_W-1:0] CAP_RESET = 16'hFFFF;

  // raw operation codes on the input
  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 3'd0,
    OP_RELEASE = 3'd1,
    OP_CHANGE  = 3'd2,
    OP_MERGE   = 3'd3,
    OP_SET_CAP = 3'd4
  } op_t;

  // classified command kind
  typedef enum logic [2:0] {
    K_ENQUEUE,
    K_RELEASE,
    K_CHANGE,
    K_MERGE,
    K_SET_CAP,
    K_INVALID
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_INACTIVE = 3'd2,
    ST_INVALID  = 3'd3,
    ST_ZERO_CAP = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ_HEAD,
    S_ADMIT,
    S_STATUS
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   holder;
    logic [ID_W-1:0]   other;
    logic [AMT_W-1:0]  amount;
    logic              h_ok;
    logic              o_ok;
    logic              same;
  } cmd_t;

  typedef struct packed {
    logic              grant_valid;
    logic [ID_W-1:0]   grant_id;
    logic [AMT_W-1:0]  grant_amount;
    logic [USE_W-1:0]  in_use;
    status_t           status;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/wfs_front.sv =====
// front end: unpacks and classifies incoming operations
`timescale 1ns / 1ps
`default_nettype none

module wfs_front #(
  parameter int HOLDERS = wfs_pkg::DEFAULT_HOLDERS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [wfs_pkg::IN_W-1:0]  in_data,
  output logic                           q_push,
  output wfs_pkg::cmd_t                  q_cmd,
  input  wire logic                      q_full
);

  localparam int SLOTS = (HOLDERS < (1 << wfs_pkg::ID_W)) ? HOLDERS : (1 << wfs_pkg::ID_W);

  logic [wfs_pkg::OP_W-1:0]  op_raw;
  logic [wfs_pkg::ID_W-1:0]  holder;
  logic [wfs_pkg::ID_W-1:0]  other;
  logic [wfs_pkg::AMT_W-1:0] amount;
  wfs_pkg::kind_t            kind;

  assign op_raw = in_data[2:0];
  assign holder = in_data[6:3];
  assign other  = in_data[10:7];
  assign amount = in_data[26:11];

  always_comb begin
    case (op_raw)
      wfs_pkg::OP_ENQUEUE: kind = wfs_pkg::K_ENQUEUE;
      wfs_pkg::OP_RELEASE: kind = wfs_pkg::K_RELEASE;
      wfs_pkg::OP_CHANGE:  kind = wfs_pkg::K_CHANGE;
      wfs_pkg::OP_MERGE:   kind = wfs_pkg::K_MERGE;
      wfs_pkg::OP_SET_CAP: kind = wfs_pkg::K_SET_CAP;
      default:             kind = wfs_pkg::K_INVALID;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.kind   = kind;
    q_cmd.holder = holder;
    q_cmd.other  = other;
    q_cmd.amount = amount;
    q_cmd.h_ok   = int'(holder) < SLOTS;
    q_cmd.o_ok   = int'(other) < SLOTS;
    q_cmd.same   = (holder == other);
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push while queue full");

endmodule

`default_nettype wire

// ===== rtl/wfs_cmd_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module wfs_cmd_queue #(
  parameter int DEPTH = wfs_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire wfs_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output wfs_pkg::cmd_t      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wfs_pkg::cmd_t  entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wfs_ram.sv =====
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module wfs_ram #(
  parameter int WIDTH = wfs_pkg::AMT_W,
  parameter int DEPTH = wfs_pkg::DEFAULT_HOLDERS
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic                      re_a,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr_a,
  output logic      [WIDTH-1:0]          rdata_a,
  input  wire logic                      re_b,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr_b,
  output logic      [WIDTH-1:0]          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wfs_back.sv =====
// back end: executes commands, runs fifo admission, drives the result register
`timescale 1ns / 1ps
`default_nettype none

module wfs_back #(
  parameter int HOLDERS = wfs_pkg::DEFAULT_HOLDERS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire wfs_pkg::cmd_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output wfs_pkg::result_t   out_data
);

  localparam int SLOTS = (HOLDERS < (1 << wfs_pkg::ID_W)) ? HOLDERS : (1 << wfs_pkg::ID_W);
  localparam int IDW   = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int UW    = wfs_pkg::USE_W;
  localparam int AW    = wfs_pkg::AMT_W;

  wfs_pkg::state_t   state, state_next;
  wfs_pkg::cmd_t     cmd;
  wfs_pkg::status_t  st, st_next;
  logic [SLOTS-1:0]  granted, granted_next;
  logic [SLOTS-1:0]  waiting, waiting_next;
  logic [IDW-1:0]    order [SLOTS];
  logic [IDW-1:0]    order_next [SLOTS];
  logic [IDW-1:0]    order_drop [SLOTS];
  logic [LW-1:0]     wait_len, wait_len_next;
  logic [UW-1:0]     in_use, in_use_next;
  logic [AW-1:0]     capacity, capacity_next;

  logic              we;
  logic [IDW-1:0]    waddr;
  logic [AW-1:0]     wdata;
  logic              re_a;
  logic [IDW-1:0]    raddr_a;
  logic [AW-1:0]     rd_a;
  logic              re_b;
  logic [AW-1:0]     rd_b;

  logic [IDW-1:0]    hidx;
  logic [IDW-1:0]    oidx;
  logic [IDW-1:0]    drop_id;
  logic              h_active;
  logic [AW:0]       merge_sum;
  logic [UW:0]       head_sum;
  logic              fits;
  logic              out_free;
  logic              grant_now;
  logic              emit;
  wfs_pkg::result_t  res_next;

  assign hidx      = cmd.holder[IDW-1:0];
  assign oidx      = cmd.other[IDW-1:0];
  assign h_active  = cmd.h_ok && (granted[hidx] || waiting[hidx]);
  assign merge_sum = {1'b0, rd_a} + {1'b0, rd_b};
  assign head_sum  = {1'b0, in_use} + (UW + 1)'(rd_a);
  assign fits      = (in_use == '0) || (head_sum <= (UW + 1)'(capacity));
  assign out_free  = !out_valid || out_ready;
  assign grant_now = (state == wfs_pkg::S_ADMIT) && out_free && (wait_len != '0) && fits;
  assign drop_id   = (state == wfs_pkg::S_ADMIT) ? order[0] : hidx;

  // amounts of holders; an entry is always written on enqueue before its value is used
  wfs_ram #(
    .WIDTH (AW),
    .DEPTH (SLOTS)
  ) u_amount_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .re_b    (re_b),
    .raddr_b (q_data.other[IDW-1:0]),
    .rdata_b (rd_b)
  );

  // remove drop_id from the wait queue, later waiters move up one place
  always_comb begin
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      hit = hit || ((LW'(i) < wait_len) && (order[i] == drop_id));
      order_drop[i] = hit ? order[(i + 1) % SLOTS] : order[i];
    end
  end

  always_comb begin
    state_next    = state;
    st_next       = st;
    granted_next  = granted;
    waiting_next  = waiting;
    order_next    = order;
    wait_len_next = wait_len;
    in_use_next   = in_use;
    capacity_next = capacity;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = hidx;
    wdata         = cmd.amount;
    re_a          = 1'b0;
    raddr_a       = q_data.holder[IDW-1:0];
    re_b          = 1'b0;
    emit          = 1'b0;
    res_next      = '0;

    case (state)
      wfs_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          re_a       = 1'b1;
          re_b       = 1'b1;
          state_next = wfs_pkg::S_EXEC;
        end
      end

      wfs_pkg::S_EXEC: begin
        st_next = wfs_pkg::ST_OK;
        case (cmd.kind)
          wfs_pkg::K_ENQUEUE: begin
            if (!cmd.h_ok) begin
              st_next = wfs_pkg::ST_INACTIVE;
            end else if (h_active) begin
              st_next = wfs_pkg::ST_BUSY;
            end else begin
              we                 = 1'b1;
              waiting_next[hidx] = 1'b1;
              for (int i = 0; i < SLOTS; i++) begin
                if (LW'(i) == wait_len) begin
                  order_next[i] = hidx;
                end
              end
              wait_len_next = wait_len + 1'b1;
            end
          end
          wfs_pkg::K_RELEASE: begin
            if (!h_active) begin
              st_next = wfs_pkg::ST_INACTIVE;
            end else if (granted[hidx]) begin
              in_use_next        = in_use - UW'(rd_a);
              granted_next[hidx] = 1'b0;
            end else begin
              order_next         = order_drop;
              waiting_next[hidx] = 1'b0;
              wait_len_next      = wait_len - 1'b1;
            end
          end
          wfs_pkg::K_CHANGE: begin
            if (!h_active) begin
              st_next = wfs_pkg::ST_INACTIVE;
            end else begin
              we = 1'b1;
              if (granted[hidx]) begin
                in_use_next = in_use - UW'(rd_a) + UW'(cmd.amount);
              end
            end
          end
          wfs_pkg::K_MERGE: begin
            if (!cmd.h_ok || !cmd.o_ok || cmd.same || !granted[hidx] || !granted[oidx]) begin
              st_next = wfs_pkg::ST_INVALID;
            end else if (merge_sum[AW]) begin
              st_next = wfs_pkg::ST_INVALID;
            end else begin
              we                 = 1'b1;
              wdata              = merge_sum[AW-1:0];
              granted_next[oidx] = 1'b0;
            end
          end
          wfs_pkg::K_SET_CAP: begin
            if (cmd.amount == '0) begin
              st_next = wfs_pkg::ST_ZERO_CAP;
            end else begin
              capacity_next = cmd.amount;
            end
          end
          default: begin
            st_next = wfs_pkg::ST_INVALID;
          end
        endcase
        state_next = (st_next == wfs_pkg::ST_OK) ? wfs_pkg::S_READ_HEAD : wfs_pkg::S_STATUS;
      end

      wfs_pkg::S_READ_HEAD: begin
        re_a       = 1'b1;
        raddr_a    = order[0];
        state_next = wfs_pkg::S_ADMIT;
      end

      wfs_pkg::S_ADMIT: begin
        if (grant_now) begin
          emit                  = 1'b1;
          res_next.grant_valid  = 1'b1;
          res_next.grant_id     = wfs_pkg::ID_W'(order[0]);
          res_next.grant_amount = rd_a;
          res_next.in_use       = in_use + UW'(rd_a);
          res_next.status       = wfs_pkg::ST_OK;
          in_use_next           = in_use + UW'(rd_a);
          order_next            = order_drop;
          waiting_next[order[0]] = 1'b0;
          granted_next[order[0]] = 1'b1;
          wait_len_next         = wait_len - 1'b1;
          // next head slides into place 0, fetch its amount now
          re_a                  = 1'b1;
          raddr_a               = order[1];
        end else if (out_free) begin
          emit            = 1'b1;
          res_next.in_use = in_use;
          res_next.status = wfs_pkg::ST_OK;
          res_next.last   = 1'b1;
          state_next      = wfs_pkg::S_IDLE;
        end
      end

      wfs_pkg::S_STATUS: begin
        if (out_free) begin
          emit            = 1'b1;
          res_next.in_use = in_use;
          res_next.status = st;
          res_next.last   = 1'b1;
          state_next      = wfs_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = wfs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= wfs_pkg::S_IDLE;
      st       <= wfs_pkg::ST_OK;
      granted  <= '0;
      waiting  <= '0;
      wait_len <= '0;
      in_use   <= '0;
      capacity <= wfs_pkg::CAP_RESET;
    end else begin
      state    <= state_next;
      st       <= st_next;
      granted  <= granted_next;
      waiting  <= waiting_next;
      wait_len <= wait_len_next;
      in_use   <= in_use_next;
      capacity <= capacity_next;
    end
  end

  always_ff @(posedge clk) begin
    order <= order_next;
    if (q_pop) begin
      cmd <= q_data;
    end
    if (emit) begin
      out_data <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_len_tracks_waiters: assert property (@(posedge clk) disable iff (rst)
    $countones(waiting) == int'(wait_len))
    else $error("wait length disagrees with waiting flags");

  a_granted_not_waiting: assert property (@(posedge clk) disable iff (rst)
    (granted & waiting) == '0)
    else $error("holder both granted and waiting");

  a_grant_emitted: assert property (@(posedge clk) disable iff (rst)
    grant_now |=> (out_valid && out_data.grant_valid && !out_data.last))
    else $error("grant did not reach the result register");

  a_grant_adds_units: assert property (@(posedge clk) disable iff (rst)
    grant_now |=> (in_use >= $past(in_use)))
    else $error("units in use dropped on a grant");

  a_status_is_error: assert property (@(posedge clk) disable iff (rst)
    (state == wfs_pkg::S_STATUS) |-> (st != wfs_pkg::ST_OK))
    else $error("error status path taken for a good operation");

endmodule

`default_nettype wire

// ===== rtl/weighted_fifo_semaphore_unit.sv =====
// top level of the weighted fifo semaphore unit
// flow: an accepted transaction waits in the command queue until the back end is idle; the
//   back end registers it, then registers a status result for a rejected operation, or
//   reads the queue head's amount, registering each grant and then a final result, for a good
//   one; commands are handled one at a time by the single admission loop and registered ram read
// reset: flags, queue length, units in use cleared, capacity 65535, command queue empty;
//   holder amounts are not cleared, each is written on enqueue before its value is used
`timescale 1ns / 1ps
`default_nettype none

module weighted_fifo_semaphore_unit #(
  parameter int HOLDERS = wfs_pkg::DEFAULT_HOLDERS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // op[2:0], holder_id[6:3], other_id[10:7], amount[26:11], zero fill
  input  wire logic [wfs_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // grant_id[3:0], grant_amount[19:4], in_use[39:20], status[42:40], zero fill
  output logic      [wfs_pkg::OUT_W-1:0]  m_axis_tdata,
  // grant_valid
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  wfs_pkg::cmd_t     q_in;
  wfs_pkg::cmd_t     q_out;
  wfs_pkg::result_t  res;

  wfs_front #(
    .HOLDERS (HOLDERS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_push   (q_push),
    .q_cmd    (q_in),
    .q_full   (q_full)
  );

  wfs_cmd_queue #(
    .DEPTH (wfs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  wfs_back #(
    .HOLDERS (HOLDERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {5'b0, res.status, res.in_use, res.grant_amount, res.grant_id};
  assign m_axis_tuser = res.grant_valid;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== tb/wfs_result_checker.sv =====
// result checker for the weighted fifo semaphore unit: predicts every result and compares it
`timescale 1ns / 1ps

module wfs_result_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  input  wire logic                      s_tready,
  input  wire logic [wfs_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                      m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic [wfs_pkg::OUT_W-1:0] m_tdata,
  input  wire logic                      m_tuser,
  input  wire logic                      m_tlast,
  output int                             mismatches,
  output int                             pending,
  output int                             grants_seen,
  output int                             statuses_seen,
  output logic [15:0]                    granted_map,
  output logic [15:0]                    waiting_map
);

  localparam int SLOTS   = wfs_pkg::DEFAULT_HOLDERS;
  localparam int ID_W    = wfs_pkg::ID_W;
  localparam int AMT_W   = wfs_pkg::AMT_W;
  localparam int USE_W   = wfs_pkg::USE_W;
  localparam int ST_W    = wfs_pkg::ST_W;
  localparam int OP_W    = wfs_pkg::OP_W;
  localparam int OUT_W   = wfs_pkg::OUT_W;
  localparam int AMT_LO  = ID_W;
  localparam int USE_LO  = AMT_LO + AMT_W;
  localparam int ST_LO   = USE_LO + USE_W;
  localparam int FILL_LO = ST_LO + ST_W;

  typedef struct {
    logic              grant_valid;
    logic [ID_W-1:0]   grant_id;
    logic [AMT_W-1:0]  grant_amount;
    logic [USE_W-1:0]  in_use;
    wfs_pkg::status_t  status;
    logic              last;
  } report_t;

  // predicted semaphore state
  logic [AMT_W-1:0] slot_units [SLOTS];
  logic [USE_W:0]   units_held;
  logic [AMT_W-1:0] capacity;
  logic [ID_W-1:0]  wait_line [$];
  report_t          expected_reports [$];

  function automatic void post_report(input logic gv, input logic [ID_W-1:0] id,
                                      input logic [AMT_W-1:0] units,
                                      input wfs_pkg::status_t st);
    report_t r;
    r.grant_valid  = gv;
    r.grant_id     = id;
    r.grant_amount = units;
    r.in_use       = units_held[USE_W-1:0];
    r.status       = st;
    r.last         = !gv;
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic void apply_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] h,
                                   input logic [ID_W-1:0] o, input logic [AMT_W-1:0] amt);
    wfs_pkg::status_t st;
    logic             active;
    logic [ID_W-1:0]  head;
    st     = wfs_pkg::ST_OK;
    active = granted_map[h] | waiting_map[h];
    case (op)
      wfs_pkg::OP_ENQUEUE: begin
        if (active) st = wfs_pkg::ST_BUSY;
        else begin
          slot_units[h]  = amt;
          waiting_map[h] = 1'b1;
          wait_line.insert(wait_line.size(), h);
        end
      end
      wfs_pkg::OP_RELEASE: begin
        if (!active) st = wfs_pkg::ST_INACTIVE;
        else begin
          if (granted_map[h]) begin
            units_held     = units_held - slot_units[h];
            granted_map[h] = 1'b0;
          end else begin
            // later waiters move up
            for (int i = 0; i < wait_line.size(); i++) begin
              if (wait_line[i] == h) begin
                wait_line.delete(i);
                break;
              end
            end
            waiting_map[h] = 1'b0;
          end
          slot_units[h] = '0;
        end
      end
      wfs_pkg::OP_CHANGE: begin
        if (!active) st = wfs_pkg::ST_INACTIVE;
        else begin
          if (granted_map[h]) units_held = units_held - slot_units[h] + amt;
          slot_units[h] = amt;
        end
      end
      wfs_pkg::OP_MERGE: begin
        if (h == o || !granted_map[h] || !granted_map[o] ||
            {1'b0, slot_units[h]} + {1'b0, slot_units[o]} > 17'h0FFFF) begin
          st = wfs_pkg::ST_INVALID;
        end else begin
          slot_units[h]  = slot_units[h] + slot_units[o];
          slot_units[o]  = '0;
          granted_map[o] = 1'b0;
        end
      end
      wfs_pkg::OP_SET_CAP: begin
        if (amt == '0) st = wfs_pkg::ST_ZERO_CAP;
        else capacity = amt;
      end
      default: st = wfs_pkg::ST_INVALID;
    endcase

    if (st == wfs_pkg::ST_OK) begin
      // a head that does not fit still runs when nothing is held
      while (wait_line.size() > 0) begin
        head = wait_line[0];
        if (units_held != '0 && units_held + slot_units[head] > {5'd0, capacity}) break;
        units_held = units_held + slot_units[head];
        void'(wait_line.pop_front());
        waiting_map[head] = 1'b0;
        granted_map[head] = 1'b1;
        post_report(1'b1, head, slot_units[head], wfs_pkg::ST_OK);
      end
    end
    post_report(1'b0, '0, '0, st);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    report_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_units[i] = '0;
      granted_map = '0;
      waiting_map = '0;
      units_held  = '0;
      capacity    = wfs_pkg::CAP_RESET;
      wait_line.delete();
      expected_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction arrived with nothing expected");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("grant_valid", 32'(want.grant_valid), 32'(m_tuser));
          check_field("grant_id", 32'(want.grant_id), 32'(m_tdata[ID_W-1:0]));
          check_field("grant_amount", 32'(want.grant_amount),
                      32'(m_tdata[USE_LO-1:AMT_LO]));
          check_field("in_use", 32'(want.in_use), 32'(m_tdata[ST_LO-1:USE_LO]));
          check_field("status", 32'(want.status), 32'(m_tdata[FILL_LO-1:ST_LO]));
          check_field("last", 32'(want.last), 32'(m_tlast));
          check_field("zero fill", '0, 32'(m_tdata[OUT_W-1:FILL_LO]));
          if (want.grant_valid) grants_seen++;
          else statuses_seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        apply_op(s_tdata[OP_W-1:0], s_tdata[OP_W+ID_W-1:OP_W],
                 s_tdata[OP_W+2*ID_W-1:OP_W+ID_W],
                 s_tdata[OP_W+2*ID_W+AMT_W-1:OP_W+2*ID_W]);
      end
    end
    pending = expected_reports.size();
  end

endmodule

// ===== tb/tb_weighted_fifo_semaphore_unit.sv =====
// testbench top for the weighted fifo semaphore unit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_weighted_fifo_semaphore_unit;

  localparam int CLK_PERIOD  = 10;
  localparam int RANDOM_OPS  = 200;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 40;
  localparam int OP_W        = wfs_pkg::OP_W;
  localparam int ID_W        = wfs_pkg::ID_W;
  localparam int AMT_W       = wfs_pkg::AMT_W;
  localparam int IN_W        = wfs_pkg::IN_W;
  localparam int OUT_W       = wfs_pkg::OUT_W;
  localparam logic [OP_W-1:0] OP_TOP = '1;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  int          mismatches;
  int          pending;
  int          grants_seen;
  int          statuses_seen;
  logic [15:0] granted_map;
  logic [15:0] waiting_map;

  int ops_sent = 0;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  weighted_fifo_semaphore_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  wfs_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .m_tuser       (m_axis_tuser),
    .m_tlast       (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .grants_seen   (grants_seen),
    .statuses_seen (statuses_seen),
    .granted_map   (granted_map),
    .waiting_map   (waiting_map)
  );

  task automatic issue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] h,
                       input logic [ID_W-1:0] o, input logic [AMT_W-1:0] amt);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {{(IN_W - OP_W - 2 * ID_W - AMT_W){1'b0}}, amt, o, h, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    ops_sent++;
    @(negedge clk);
  endtask

  // random member of a slot set, any slot when the set is empty
  function automatic logic [ID_W-1:0] pick_slot(input logic [15:0] mask);
    int n;
    int k;
    n = $countones(mask);
    if (n == 0) return ID_W'($urandom_range(0, 15));
    k = $urandom_range(0, n - 1);
    for (int i = 0; i < 16; i++) begin
      if (mask[i]) begin
        if (k == 0) return ID_W'(i);
        k--;
      end
    end
    return '0;
  endfunction

  // mostly modest requests so that grants keep flowing, now and then a huge one
  function automatic logic [AMT_W-1:0] draw_amount();
    if ($urandom_range(0, 4) == 0) return AMT_W'($urandom);
    return AMT_W'($urandom_range(0, 1500));
  endfunction

  function automatic logic [AMT_W-1:0] draw_capacity();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'd1;
      2: return '1;
      default: return AMT_W'($urandom_range(2000, 8000));
    endcase
  endfunction

  initial begin : stimulus
    int r;
    logic [ID_W-1:0] h;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    issue(wfs_pkg::OP_ENQUEUE, 4'd0, 4'd0, 16'hFFFF);   // fills the whole capacity
    issue(wfs_pkg::OP_ENQUEUE, 4'd0, 4'd0, 16'd5);      // busy slot
    issue(wfs_pkg::OP_ENQUEUE, 4'd15, 4'd0, 16'd1);     // has to wait
    issue(wfs_pkg::OP_SET_CAP, 4'd0, 4'd0, 16'd0);      // zero capacity refused
    for (int k = int'(wfs_pkg::OP_SET_CAP) + 1; k <= int'(OP_TOP); k++)
      issue(OP_W'(k), 4'hF, 4'hF, 16'hFFFF);
    issue(wfs_pkg::OP_RELEASE, 4'd3, 4'd0, 16'd0);      // inactive slot
    issue(wfs_pkg::OP_CHANGE, 4'd3, 4'd0, 16'd9);
    issue(wfs_pkg::OP_MERGE, 4'd0, 4'd0, 16'd0);        // merge into itself
    issue(wfs_pkg::OP_MERGE, 4'd0, 4'd15, 16'd0);       // other one still waiting
    issue(wfs_pkg::OP_SET_CAP, 4'd0, 4'd0, 16'd100);
    issue(wfs_pkg::OP_CHANGE, 4'd0, 4'd0, 16'd50);      // shrink lets the waiter in
    issue(wfs_pkg::OP_ENQUEUE, 4'd7, 4'd0, 16'd200);
    issue(wfs_pkg::OP_ENQUEUE, 4'd8, 4'd0, 16'd10);
    issue(wfs_pkg::OP_RELEASE, 4'd7, 4'd0, 16'd0);      // cancel from the queue head
    issue(wfs_pkg::OP_MERGE, 4'd0, 4'd15, 16'd0);
    issue(wfs_pkg::OP_ENQUEUE, 4'd1, 4'd0, 16'hFFFF);
    issue(wfs_pkg::OP_CHANGE, 4'd1, 4'd0, 16'd40);      // waiter only keeps its new amount
    issue(wfs_pkg::OP_CHANGE, 4'd0, 4'd0, 16'hFFFF);    // use grows past capacity
    issue(wfs_pkg::OP_MERGE, 4'd0, 4'd8, 16'd0);        // sum overflows 16 bits
    issue(wfs_pkg::OP_RELEASE, 4'd0, 4'd0, 16'd0);
    issue(wfs_pkg::OP_ENQUEUE, 4'd2, 4'd0, 16'd0);
    issue(wfs_pkg::OP_SET_CAP, 4'd0, 4'd0, 16'hFFFF);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 3) hold_req <= 1'b1;
      if (n == RANDOM_OPS - 30) calm <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        issue(wfs_pkg::OP_ENQUEUE, pick_slot(~(granted_map | waiting_map)), ID_W'($urandom),
              draw_amount());
      end else if (r < 55) begin
        issue(wfs_pkg::OP_RELEASE,
              pick_slot($urandom_range(0, 3) == 0 ? waiting_map : granted_map),
              ID_W'($urandom), AMT_W'($urandom));
      end else if (r < 65) begin
        issue(wfs_pkg::OP_CHANGE, pick_slot(granted_map | waiting_map), ID_W'($urandom),
              draw_amount());
      end else if (r < 78) begin
        h = pick_slot(granted_map);
        issue(wfs_pkg::OP_MERGE, h, pick_slot(granted_map & ~(16'd1 << h)),
              AMT_W'($urandom));
      end else if (r < 88) begin
        issue(wfs_pkg::OP_SET_CAP, ID_W'($urandom), ID_W'($urandom), draw_capacity());
      end else if (r < 94) begin
        issue(OP_W'($urandom_range(int'(wfs_pkg::OP_SET_CAP) + 1, int'(OP_TOP))),
              ID_W'($urandom), ID_W'($urandom), AMT_W'($urandom));
      end else begin
        issue(OP_W'($urandom), ID_W'($urandom), ID_W'($urandom), AMT_W'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d operations: %0d grants and %0d status transactions checked",
             ops_sent, grants_seen, statuses_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: short random stalls, one long hold-off, none near the end
  initial begin : receiver
    int stall_left;
    bit hold_done;
    stall_left    = 0;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (hold_req && !hold_done) begin
        hold_done     = 1'b1;
        stall_left    = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("no transaction for %0d cycles", IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wfs_pkg.sv
rtl/wfs_front.sv
rtl/wfs_cmd_queue.sv
rtl/wfs_ram.sv
rtl/wfs_back.sv
rtl/weighted_fifo_semaphore_unit.sv
tb/wfs_result_checker.sv
tb/tb_weighted_fifo_semaphore_unit.sv
